/* rtl/core/ptpod_pkg.sv */
// ----------------------------------------------------------------------------
// ptpod_pkg
// Types, constants and helpers shared by the PTP offset and delay engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptpod_pkg;

  // Width kept for stored timestamps; wider stamp bits are dropped on entry.
  localparam int unsigned StampW   = 64;
  localparam int unsigned NumSlots = 7;
  localparam int unsigned JobDepth = 4;
  localparam int unsigned OutDepth = 2;

  typedef logic [StampW-1:0] stamp_t;

  typedef enum logic [2:0] {
    KIND_SYNC   = 3'd0,
    KIND_FUP    = 3'd1,
    KIND_DREQ   = 3'd2,
    KIND_DRESP  = 3'd3,
    KIND_PDREQ  = 3'd4,
    KIND_PDRESP = 3'd5,
    KIND_PDFUP  = 3'd6,
    KIND_UNUSED = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    UPD_SYNC = 2'd0,
    UPD_E2E  = 2'd1,
    UPD_PEER = 2'd2
  } upd_e;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        seq_id;
    logic               one_step;
    logic [62:0]        tx_stamp;
    logic [62:0]        rx_stamp;
    logic [62:0]        origin_stamp;
    logic signed [63:0] correction;
  } in_item_t;

  typedef struct packed {
    upd_e               update_kind;
    logic signed [63:0] sync_term;
    logic signed [63:0] path_delay;
    logic signed [63:0] offset;
  } out_item_t;

  // One computation handed to the back end: term = (a - b) - (c - d) - (e + f).
  typedef struct packed {
    upd_e        op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    logic [63:0] e;
    logic [63:0] f;
  } job_t;

  function automatic stamp_t to_stamp(logic [62:0] v);
    logic [63:0] w;
    w = {1'b0, v};
    return w[StampW-1:0];
  endfunction

  function automatic logic [63:0] widen(stamp_t s);
    return 64'(s);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ptpod_front.sv */
// ----------------------------------------------------------------------------
// ptpod_front
// Message slots: stores each event, matches exchanges by sequence number and
// issues the operands of one computation when an exchange completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpod_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire ptpod_pkg::in_item_t item_i,
  output logic                   job_valid_o,
  output ptpod_pkg::job_t        job_o
);
  import ptpod_pkg::*;

  logic [NumSlots-1:0] valid_q, valid_d;
  logic [15:0]         seq_q    [NumSlots];
  stamp_t              local_q  [NumSlots];
  stamp_t              origin_q [NumSlots];
  logic [63:0]         corr_q   [NumSlots];

  stamp_t      cur_local, cur_origin;
  logic [63:0] cur_loc64, cur_org64, cur_corr;
  logic        is_slot;
  logic        m_sync, m_fup, m_dreq, m_pdreq, m_pdresp, m_pdfup, req_resp_ok;

  assign is_slot    = (item_i.kind != KIND_UNUSED);
  assign cur_local  = ((item_i.kind == KIND_DREQ) || (item_i.kind == KIND_PDREQ))
                      ? to_stamp(item_i.tx_stamp) : to_stamp(item_i.rx_stamp);
  assign cur_origin = to_stamp(item_i.origin_stamp);
  assign cur_loc64  = widen(cur_local);
  assign cur_org64  = widen(cur_origin);
  assign cur_corr   = item_i.correction;

  // Stored slot holds a live partner with the incoming sequence number.
  assign m_sync   = valid_q[KIND_SYNC]   && (seq_q[KIND_SYNC]   == item_i.seq_id);
  assign m_fup    = valid_q[KIND_FUP]    && (seq_q[KIND_FUP]    == item_i.seq_id);
  assign m_dreq   = valid_q[KIND_DREQ]   && (seq_q[KIND_DREQ]   == item_i.seq_id);
  assign m_pdreq  = valid_q[KIND_PDREQ]  && (seq_q[KIND_PDREQ]  == item_i.seq_id);
  assign m_pdresp = valid_q[KIND_PDRESP] && (seq_q[KIND_PDRESP] == item_i.seq_id);
  assign m_pdfup  = valid_q[KIND_PDFUP]  && (seq_q[KIND_PDFUP]  == item_i.seq_id);
  assign req_resp_ok = valid_q[KIND_PDREQ] && valid_q[KIND_PDRESP] &&
                       (seq_q[KIND_PDREQ] == seq_q[KIND_PDRESP]);

  always_comb begin
    valid_d     = valid_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    unique case (item_i.kind)
      KIND_SYNC: begin
        valid_d[KIND_SYNC] = 1'b1;
        if (item_i.one_step) begin
          job_valid_o        = 1'b1;
          job_o.op           = UPD_SYNC;
          job_o.a            = cur_loc64;
          job_o.b            = cur_org64;
          job_o.e            = cur_corr;
          valid_d[KIND_SYNC] = 1'b0;
        end else if (m_fup) begin
          job_valid_o        = 1'b1;
          job_o.op           = UPD_SYNC;
          job_o.a            = cur_loc64;
          job_o.b            = widen(origin_q[KIND_FUP]);
          job_o.e            = cur_corr;
          job_o.f            = corr_q[KIND_FUP];
          valid_d[KIND_SYNC] = 1'b0;
          valid_d[KIND_FUP]  = 1'b0;
        end
      end
      KIND_FUP: begin
        valid_d[KIND_FUP] = 1'b1;
        if (m_sync) begin
          job_valid_o        = 1'b1;
          job_o.op           = UPD_SYNC;
          job_o.a            = widen(local_q[KIND_SYNC]);
          job_o.b            = cur_org64;
          job_o.e            = corr_q[KIND_SYNC];
          job_o.f            = cur_corr;
          valid_d[KIND_SYNC] = 1'b0;
          valid_d[KIND_FUP]  = 1'b0;
        end
      end
      KIND_DREQ: begin
        valid_d[KIND_DREQ]  = 1'b1;
        valid_d[KIND_DRESP] = 1'b0;
      end
      KIND_DRESP: begin
        valid_d[KIND_DRESP] = 1'b1;
        if (m_dreq) begin
          job_valid_o         = 1'b1;
          job_o.op            = UPD_E2E;
          job_o.a             = cur_org64;
          job_o.b             = widen(local_q[KIND_DREQ]);
          job_o.e             = cur_corr;
          valid_d[KIND_DREQ]  = 1'b0;
          valid_d[KIND_DRESP] = 1'b0;
        end
      end
      KIND_PDREQ: begin
        valid_d[KIND_PDREQ]  = 1'b1;
        valid_d[KIND_PDRESP] = 1'b0;
        valid_d[KIND_PDFUP]  = 1'b0;
      end
      KIND_PDRESP: begin
        valid_d[KIND_PDRESP] = 1'b1;
        if (m_pdreq && (item_i.one_step || m_pdfup)) begin
          job_valid_o          = 1'b1;
          job_o.op             = UPD_PEER;
          job_o.a              = cur_loc64;
          job_o.b              = widen(local_q[KIND_PDREQ]);
          job_o.e              = cur_corr;
          if (!item_i.one_step) begin
            job_o.c = widen(origin_q[KIND_PDFUP]);
            job_o.d = cur_org64;
            job_o.f = corr_q[KIND_PDFUP];
          end
          valid_d[KIND_PDREQ]  = 1'b0;
          valid_d[KIND_PDRESP] = 1'b0;
          valid_d[KIND_PDFUP]  = 1'b0;
        end
      end
      KIND_PDFUP: begin
        valid_d[KIND_PDFUP] = 1'b1;
        if (req_resp_ok && m_pdresp) begin
          job_valid_o          = 1'b1;
          job_o.op             = UPD_PEER;
          job_o.a              = widen(local_q[KIND_PDRESP]);
          job_o.b              = widen(local_q[KIND_PDREQ]);
          job_o.c              = cur_org64;
          job_o.d              = widen(origin_q[KIND_PDRESP]);
          job_o.e              = corr_q[KIND_PDRESP];
          job_o.f              = cur_corr;
          valid_d[KIND_PDREQ]  = 1'b0;
          valid_d[KIND_PDRESP] = 1'b0;
          valid_d[KIND_PDFUP]  = 1'b0;
        end
      end
      default: begin
        // The unused kind code touches nothing.
        valid_d = valid_q;
      end
    endcase
    if (!accept_i) begin
      job_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (accept_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && is_slot) begin
      seq_q[item_i.kind]    <= item_i.seq_id;
      local_q[item_i.kind]  <= cur_local;
      origin_q[item_i.kind] <= cur_origin;
      corr_q[item_i.kind]   <= cur_corr;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ptpod_job_queue.sv */
// ----------------------------------------------------------------------------
// ptpod_job_queue
// Short queue of pending computations between the slot front end and the
// arithmetic back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpod_job_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ptpod_pkg::job_t job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output ptpod_pkg::job_t      job_o
);
  import ptpod_pkg::*;

  localparam int unsigned PtrW = (JobDepth > 1) ? $clog2(JobDepth) : 1;
  localparam int unsigned CntW = $clog2(JobDepth + 1);

  job_t            mem_q [JobDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(JobDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ptpod_back.sv */
// ----------------------------------------------------------------------------
// ptpod_back
// Arithmetic pipeline: forms the exchange term, updates the sync term and
// path delay, and queues the result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpod_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_empty_i,
  input  wire ptpod_pkg::job_t job_i,
  output logic                 job_pop_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output ptpod_pkg::out_item_t out_item_o
);
  import ptpod_pkg::*;

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  // Halving that truncates toward zero: bias negative values by one first.
  function automatic logic [63:0] halve(logic [63:0] x);
    logic [63:0] s;
    s = x + {63'b0, x[63]};
    return {s[63], s[63:1]};
  endfunction

  logic        adv;
  logic        s1_valid_q, s2_valid_q, emit_q;
  upd_e        s1_op_q, s2_op_q, emit_kind_q;
  logic [63:0] p_q, q_q, r_q, term_q;
  logic [63:0] sync_q, sync_d, delay_q, delay_d;

  out_item_t       out_mem_q [OutDepth];
  out_item_t       out_wr;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            out_full, out_push, out_pop;

  assign out_full  = (count_q == CntW'(OutDepth));
  assign empty_o   = (count_q == '0);
  assign out_push  = emit_q && !out_full;
  assign out_pop   = pop_i && !empty_o;
  assign out_item_o = out_mem_q[rd_ptr_q];

  // The whole pipeline holds while a finished result finds no room.
  assign adv       = !(emit_q && out_full);
  assign job_pop_o = adv && !job_empty_i;

  always_comb begin
    sync_d  = sync_q;
    delay_d = delay_q;
    if (s2_valid_q) begin
      unique case (s2_op_q)
        UPD_SYNC: sync_d  = term_q;
        UPD_E2E:  delay_d = halve(sync_q + term_q);
        UPD_PEER: delay_d = halve(term_q);
        default:  sync_d  = sync_q;
      endcase
    end
  end

  always_comb begin
    out_wr.update_kind = emit_kind_q;
    out_wr.sync_term   = sync_q;
    out_wr.path_delay  = delay_q;
    out_wr.offset      = sync_q - delay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      emit_q     <= 1'b0;
      sync_q     <= '0;
      delay_q    <= '0;
    end else if (adv) begin
      s1_valid_q <= !job_empty_i;
      s2_valid_q <= s1_valid_q;
      emit_q     <= s2_valid_q;
      sync_q     <= sync_d;
      delay_q    <= delay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q     <= job_i.op;
      p_q         <= job_i.a - job_i.b;
      q_q         <= job_i.c - job_i.d;
      r_q         <= job_i.e + job_i.f;
      s2_op_q     <= s1_op_q;
      term_q      <= p_q - q_q - r_q;
      emit_kind_q <= s2_op_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (out_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (out_push && !out_pop) begin
        count_q <= count_q + 1'b1;
      end else if (out_pop && !out_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[wr_ptr_q] <= out_wr;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ptp_offset_delay_engine.sv */
// ----------------------------------------------------------------------------
// ptp_offset_delay_engine
// Path: an event that completes its exchange passes through the job queue,
//   the arithmetic pipeline and the result queue before its beat shows.
// Throughput: one event per cycle while the job queue is not full; the
//   arithmetic pipeline takes one computation per cycle and stalls only when the result queue is full.
// Reset: all slots empty, sync term and path delay zero, both queues empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptp_offset_delay_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire ptpod_pkg::in_item_t  in_item_i,
  output logic                      empty,
  input  wire logic                 pop,
  output ptpod_pkg::out_item_t      out_item_o
);
  import ptpod_pkg::*;

  logic accept;
  logic job_valid, job_empty, job_pop;
  job_t job_in, job_out;

  assign accept = push && !full;

  ptpod_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  ptpod_job_queue u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .job_o   (job_out)
  );

  ptpod_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ptp_offset_delay_engine. An in-bench tracker keeps
// its own copy of the message slots, the sync term and the path delay. It
// predicts the update beat that each accepted event causes, and it checks
// every popped beat field by field against the oldest prediction. The run
// starts with directed exchanges and corner cases, then mostly well-formed
// random exchanges mixed with broken ones and noise. Both sides idle in
// random bursts, and the run includes one long output stall and two drains.
// ----------------------------------------------------------------------------

module tb;
  import ptpod_pkg::*;

  localparam int unsigned TotalItems  = 1450;
  localparam int unsigned QuietItems  = 150;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 300000;

  localparam logic [62:0]        MaxStamp    = {63{1'b1}};
  localparam logic signed [63:0] MinCorr     = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MaxCorr     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]        StampMask   = {64{1'b1}} >> (64 - StampW);

  class ptp_update_tracker;
    logic        slot_vld [NumSlots];
    logic [15:0] slot_seq [NumSlots];
    logic [63:0] slot_loc [NumSlots];
    logic [63:0] slot_org [NumSlots];
    logic [63:0] slot_cor [NumSlots];
    logic [63:0] sync_term;
    logic [63:0] path_delay;
    logic [63:0] reverse_term;
    out_item_t   pending_updates [$];
    int unsigned mismatches;
    int unsigned seen_by_kind [3];

    function new();
      for (int i = 0; i < NumSlots; i++) begin
        slot_vld[i] = 1'b0;
      end
      sync_term    = '0;
      path_delay   = '0;
      reverse_term = '0;
      mismatches   = 0;
      seen_by_kind = '{default: 0};
    endfunction

    function logic [63:0] halve_toward_zero(logic [63:0] v);
      logic [63:0] mag;
      mag = v[63] ? -v : v;
      mag = mag >> 1;
      return v[63] ? -mag : mag;
    endfunction

    function bit paired(kind_e a, kind_e b);
      return slot_vld[a] && slot_vld[b] && slot_seq[a] == slot_seq[b];
    endfunction

    function void queue_update(upd_e kind);
      out_item_t exp;
      exp.update_kind = kind;
      exp.sync_term   = sync_term;
      exp.path_delay  = path_delay;
      exp.offset      = sync_term - path_delay;
      pending_updates.push_back(exp);
    endfunction

    function void note_event(in_item_t ev);
      logic [2:0] k;
      logic       peer_done;
      k = ev.kind;
      peer_done = 1'b0;
      if (k == KIND_UNUSED) return;
      slot_vld[k] = 1'b1;
      slot_seq[k] = ev.seq_id;
      if (k == KIND_DREQ || k == KIND_PDREQ) slot_loc[k] = StampMask & {1'b0, ev.tx_stamp};
      else slot_loc[k] = StampMask & {1'b0, ev.rx_stamp};
      slot_org[k] = StampMask & {1'b0, ev.origin_stamp};
      slot_cor[k] = ev.correction;
      case (k)
        KIND_SYNC, KIND_FUP: begin
          if (k == KIND_SYNC && ev.one_step) begin
            sync_term = slot_loc[KIND_SYNC] - slot_org[KIND_SYNC] - slot_cor[KIND_SYNC];
            slot_vld[KIND_SYNC] = 1'b0;
            queue_update(UPD_SYNC);
          end else if (paired(KIND_SYNC, KIND_FUP)) begin
            sync_term = slot_loc[KIND_SYNC] - slot_org[KIND_FUP]
                        - slot_cor[KIND_SYNC] - slot_cor[KIND_FUP];
            slot_vld[KIND_SYNC] = 1'b0;
            slot_vld[KIND_FUP]  = 1'b0;
            queue_update(UPD_SYNC);
          end
        end
        KIND_DREQ: slot_vld[KIND_DRESP] = 1'b0;
        KIND_DRESP: begin
          if (paired(KIND_DREQ, KIND_DRESP)) begin
            reverse_term = slot_org[KIND_DRESP] - slot_loc[KIND_DREQ] - slot_cor[KIND_DRESP];
            path_delay   = halve_toward_zero(sync_term + reverse_term);
            slot_vld[KIND_DREQ]  = 1'b0;
            slot_vld[KIND_DRESP] = 1'b0;
            queue_update(UPD_E2E);
          end
        end
        KIND_PDREQ: begin
          slot_vld[KIND_PDRESP] = 1'b0;
          slot_vld[KIND_PDFUP]  = 1'b0;
        end
        default: begin
          // A one-step response closes the exchange alone; a two-step one
          // needs its follow-up, which may arrive on either side of it.
          if (k == KIND_PDRESP && ev.one_step) begin
            if (paired(KIND_PDREQ, KIND_PDRESP)) begin
              path_delay = halve_toward_zero(slot_loc[KIND_PDRESP] - slot_loc[KIND_PDREQ]
                                             - slot_cor[KIND_PDRESP]);
              peer_done  = 1'b1;
            end
          end else if (paired(KIND_PDREQ, KIND_PDRESP) && paired(KIND_PDRESP, KIND_PDFUP)) begin
            path_delay = halve_toward_zero((slot_loc[KIND_PDRESP] - slot_loc[KIND_PDREQ])
                                           - (slot_org[KIND_PDFUP] - slot_org[KIND_PDRESP])
                                           - slot_cor[KIND_PDRESP] - slot_cor[KIND_PDFUP]);
            peer_done  = 1'b1;
          end
          if (peer_done) begin
            slot_vld[KIND_PDREQ]  = 1'b0;
            slot_vld[KIND_PDRESP] = 1'b0;
            slot_vld[KIND_PDFUP]  = 1'b0;
            queue_update(UPD_PEER);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_update(out_item_t got);
      out_item_t exp;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected update beat: expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      exp = pending_updates.pop_front();
      compare_field("update_kind", 64'(exp.update_kind), 64'(got.update_kind));
      compare_field("sync_term", exp.sync_term, got.sync_term);
      compare_field("path_delay", exp.path_delay, got.path_delay);
      compare_field("offset", exp.offset, got.offset);
      if (exp.update_kind <= UPD_PEER) seen_by_kind[exp.update_kind]++;
    endfunction

    function int unsigned outstanding();
      return pending_updates.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  ev_drv;
  logic      empty;
  logic      pop;
  out_item_t upd_mon;

  ptp_update_tracker tracker;
  int unsigned items_sent;
  int unsigned ignored_sent;
  int unsigned send_gap_rate;
  int unsigned rcv_gap_rate;
  bit          quiet;
  bit          long_hold_req;

  ptp_offset_delay_engine u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (ev_drv),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (upd_mon)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [62:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return MaxStamp;
      2: return 63'($urandom_range(0, 1000));
      default: return w[62:0];
    endcase
  endfunction

  function automatic logic signed [63:0] rand_corr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return MinCorr;
      1: return MaxCorr;
      2: return 64'(int'($urandom_range(0, 2000)) - 1000);
      default: return w;
    endcase
  endfunction

  function automatic in_item_t make_event(logic [2:0] k, logic [15:0] seq, logic os);
    in_item_t ev;
    ev.kind         = kind_e'(k);
    ev.seq_id       = seq;
    ev.one_step     = os;
    ev.tx_stamp     = rand_stamp();
    ev.rx_stamp     = rand_stamp();
    ev.origin_stamp = rand_stamp();
    ev.correction   = rand_corr();
    return ev;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Holds push low; the data lines carry junk meanwhile.
  task automatic sender_idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      push   <= 1'b0;
      ev_drv <= make_event(3'($urandom_range(0, 7)), 16'($urandom), rand_bit());
    end
  endtask

  task automatic send_event(input in_item_t ev);
    @(negedge clk_i);
    push   <= 1'b1;
    ev_drv <= ev;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.note_event(ev);
    items_sent++;
    if (ev.kind == KIND_UNUSED) ignored_sent++;
  endtask

  task automatic send_with_gaps(input in_item_t ev);
    if (!quiet && send_gap_rate != 0 && $urandom_range(0, send_gap_rate - 1) == 0) begin
      sender_idle($urandom_range(1, 12));
    end
    send_event(ev);
  endtask

  task automatic wait_for_drain();
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic directed_exchanges();
    in_item_t ev;
    // One-step syncs at the stamp and correction extremes.
    ev = make_event(KIND_SYNC, 16'h0000, 1'b1);
    ev.rx_stamp = MaxStamp;  ev.origin_stamp = '0;  ev.correction = MinCorr;
    send_with_gaps(ev);
    ev = make_event(KIND_SYNC, 16'hFFFF, 1'b1);
    ev.rx_stamp = '0;  ev.origin_stamp = MaxStamp;  ev.correction = MaxCorr;
    ev.tx_stamp = MaxStamp;
    send_with_gaps(ev);
    // A follow-up with no Sync stored, then a two-step pair.
    send_with_gaps(make_event(KIND_FUP, 16'd5, 1'b0));
    send_with_gaps(make_event(KIND_SYNC, 16'd7, 1'b0));
    send_with_gaps(make_event(KIND_FUP, 16'd7, 1'b1));
    // A request clears a stale response; a mismatched response is only stored.
    send_with_gaps(make_event(KIND_DRESP, 16'd9, 1'b0));
    ev = make_event(KIND_DREQ, 16'd9, 1'b0);
    ev.tx_stamp = 63'd3;
    send_with_gaps(ev);
    send_with_gaps(make_event(KIND_DRESP, 16'd10, 1'b1));
    ev = make_event(KIND_DRESP, 16'd9, 1'b0);
    ev.origin_stamp = '0;  ev.correction = '0;
    send_with_gaps(ev);
    // Peer one-step with an odd negative delay, then a response with no request.
    ev = make_event(KIND_PDREQ, 16'd20, 1'b0);
    ev.tx_stamp = 63'd100;
    send_with_gaps(ev);
    ev = make_event(KIND_PDRESP, 16'd20, 1'b1);
    ev.rx_stamp = 63'd97;  ev.correction = '0;
    send_with_gaps(ev);
    send_with_gaps(make_event(KIND_PDRESP, 16'd20, 1'b1));
    // Peer two-step with the follow-up first.
    send_with_gaps(make_event(KIND_PDREQ, 16'd30, 1'b1));
    send_with_gaps(make_event(KIND_PDFUP, 16'd30, 1'b0));
    send_with_gaps(make_event(KIND_PDRESP, 16'd30, 1'b0));
    // A new request cancels the exchange in progress.
    send_with_gaps(make_event(KIND_PDREQ, 16'd31, 1'b0));
    send_with_gaps(make_event(KIND_PDRESP, 16'd31, 1'b0));
    send_with_gaps(make_event(KIND_PDREQ, 16'd32, 1'b0));
    send_with_gaps(make_event(KIND_PDFUP, 16'd31, 1'b1));
    // The unused kind with every bit set must leave no trace.
    ev = '1;
    send_with_gaps(ev);
    send_with_gaps(make_event(KIND_PDRESP, 16'd32, 1'b0));
    send_with_gaps(make_event(KIND_PDFUP, 16'd32, 1'b0));
    ev = '0;
    ev.kind = KIND_DREQ;
    send_with_gaps(ev);
    ev.kind = KIND_DRESP;
    send_with_gaps(ev);
  endtask

  task automatic random_exchange();
    logic [15:0] seq;
    int unsigned pick;
    in_item_t    a;
    in_item_t    b;
    seq  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_with_gaps(make_event(KIND_SYNC, seq, 1'b1));
    end else if (pick < 35) begin
      a = make_event(KIND_SYNC, seq, 1'b0);
      b = make_event(KIND_FUP, seq, rand_bit());
      if ($urandom_range(0, 4) == 0) begin
        send_with_gaps(b);
        send_with_gaps(a);
      end else begin
        send_with_gaps(a);
        send_with_gaps(b);
      end
    end else if (pick < 55) begin
      send_with_gaps(make_event(KIND_DREQ, seq, rand_bit()));
      send_with_gaps(make_event(KIND_DRESP, seq, rand_bit()));
    end else if (pick < 67) begin
      send_with_gaps(make_event(KIND_PDREQ, seq, rand_bit()));
      send_with_gaps(make_event(KIND_PDRESP, seq, 1'b1));
    end else if (pick < 80) begin
      send_with_gaps(make_event(KIND_PDREQ, seq, rand_bit()));
      a = make_event(KIND_PDRESP, seq, 1'b0);
      b = make_event(KIND_PDFUP, seq, rand_bit());
      if (rand_bit()) begin
        send_with_gaps(b);
        send_with_gaps(a);
      end else begin
        send_with_gaps(a);
        send_with_gaps(b);
      end
    end else if (pick < 88) begin
      // Broken exchange: a partner with a neighboring sequence number, or a
      // random pair of kinds that share one.
      if (rand_bit()) begin
        send_with_gaps(make_event(KIND_DREQ, seq, rand_bit()));
        send_with_gaps(make_event(KIND_DRESP, seq + 16'd1, rand_bit()));
      end else begin
        send_with_gaps(make_event(3'($urandom_range(0, 6)), seq, rand_bit()));
        send_with_gaps(make_event(3'($urandom_range(0, 6)), seq, rand_bit()));
      end
    end else begin
      send_with_gaps(make_event(3'($urandom_range(0, 7)), 16'($urandom_range(0, 3)),
                                rand_bit()));
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHold;
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!quiet && rcv_gap_rate != 0 &&
                   $urandom_range(0, rcv_gap_rate - 1) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) tracker.check_update(upd_mon);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** ptp_offset_delay_engine: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned next_block;
    bit          hold_done;
    bit          drain_done;
    tracker       = new();
    push          = 1'b0;
    pop           = 1'b0;
    ev_drv        = '0;
    rst_ni        = 1'b0;
    items_sent    = 0;
    ignored_sent  = 0;
    send_gap_rate = 4;
    rcv_gap_rate  = 4;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    next_block    = 0;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_exchanges();

    while (items_sent < TotalItems) begin
      if (items_sent >= next_block) begin
        // Each block of events gets its own idling density, none included.
        case ($urandom_range(0, 3))
          0: send_gap_rate = 0;
          1: send_gap_rate = 3;
          2: send_gap_rate = 8;
          default: send_gap_rate = 20;
        endcase
        case ($urandom_range(0, 3))
          0: rcv_gap_rate = 0;
          1: rcv_gap_rate = 3;
          2: rcv_gap_rate = 8;
          default: rcv_gap_rate = 20;
        endcase
        next_block += 64;
      end
      if (items_sent >= TotalItems - QuietItems) quiet = 1'b1;
      if (!hold_done && items_sent >= 400) begin
        // Starve the output so the result queue fills and full backs up.
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
        repeat (40) send_event(make_event(KIND_SYNC, 16'($urandom), 1'b1));
      end
      if (!drain_done && items_sent >= 800) begin
        drain_done = 1'b1;
        sender_idle(1);
        wait_for_drain();
      end
      random_exchange();
    end

    sender_idle(1);
    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d events (%0d of the unused kind); checked %0d sync, %0d end-to-end",
             items_sent, ignored_sent, tracker.seen_by_kind[UPD_SYNC],
             tracker.seen_by_kind[UPD_E2E]);
    $display("and %0d peer delay updates, with %0d mismatches.",
             tracker.seen_by_kind[UPD_PEER], tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("** ptp_offset_delay_engine: PASSED **");
    end else begin
      $display("** ptp_offset_delay_engine: FAILED **");
    end
    $finish;
  end

endmodule
